>>> design/isort_pkg.sv
// Shared types and constants for the insertion sorter.
// No dependencies; imported by the sorter cell and the top level.
`timescale 1ns / 1ps

package isort_pkg;

   localparam int VALUE_BITS    = 32;
   localparam int MAX_ITEMS_DEF = 64;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic                         last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] sorted_value;
      logic                         final_res;
      logic                         overflow;
   } rsp_type;

   // Broadcast control from the top level to every cell.
   typedef struct packed {
      logic insert;   // place the broadcast value into the chain
      logic shift;    // move every entry one cell toward the output
   } cell_ctrl_type;

endpackage

>>> design/isort_cell.sv
// One compare-and-shift cell of the sorting chain.
// Depends on isort_pkg for the value width and the control struct.
`timescale 1ns / 1ps

module isort_cell
   import isort_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  cell_ctrl_type                ctrl,
   input  logic signed [VALUE_BITS-1:0] new_value,
   input  logic signed [VALUE_BITS-1:0] left_value,
   input  logic                         left_valid,
   input  logic                         left_ins,
   input  logic signed [VALUE_BITS-1:0] right_value,
   input  logic                         right_valid,
   output logic signed [VALUE_BITS-1:0] value,
   output logic                         valid,
   output logic                         ins
);

   logic signed [VALUE_BITS-1:0] value_ff, value_in;
   logic                         valid_ff, valid_in;

   // New value belongs at or before this cell when the cell is empty
   // or holds a value that is not smaller.
   assign ins = !valid_ff || !(value_ff < new_value);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (ctrl.insert && ins) begin
         if (left_ins) begin
            value_in = left_value;
            valid_in = left_valid;
         end else begin
            value_in = new_value;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

>>> design/insertion_sorter.sv
// Insertion sorter: top level with the cell chain and the drain control.
// Depends on isort_pkg and isort_cell.
//
// Usage:
//   Requests enter on req_data while start is high and busy is low. Each
//   accepted value is inserted into a chain of MAX_ITEMS cells in the same
//   cycle unless the chain is full, so a request that is not marked last
//   can be followed right behind it by the next one.
//   A request marked last is inserted too, then busy rises and the chain
//   drains from its head, one result per cycle on rsp_data marked by
//   rsp_valid, in ascending order. The first result appears the cycle after
//   the last request. final_res marks the final result, overflow is set
//   on every result of a run in which a request found the chain full and
//   was dropped.
//   After the drain the chain is empty and busy falls in the cycle after
//   the final result.
//   Reset empties the chain and clears the overflow flag. The receiver
//   cannot stall; results are shown for one cycle only.
`timescale 1ns / 1ps

module insertion_sorter
   import isort_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic signed [VALUE_BITS-1:0] cell_value [MAX_ITEMS];
   logic                         cell_valid [MAX_ITEMS];
   logic                         cell_ins   [MAX_ITEMS];

   logic          draining_ff, draining_in;
   logic          dropped_ff, dropped_in;
   logic          accept, full, drain_done;
   cell_ctrl_type ctrl;

   assign accept     = start && !draining_ff;
   assign full       = cell_valid[MAX_ITEMS-1];
   assign drain_done = draining_ff && !cell_valid[1];

   assign ctrl.insert = accept && !full;
   assign ctrl.shift  = draining_ff;

   always_comb begin
      draining_in = draining_ff;
      dropped_in  = dropped_ff;
      if (accept) begin
         if (full) begin
            dropped_in = 1'b1;
         end
         if (req_data.last) begin
            draining_in = 1'b1;
         end
      end else if (drain_done) begin
         draining_in = 1'b0;
         dropped_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff <= 1'b0;
         dropped_ff  <= 1'b0;
      end else begin
         draining_ff <= draining_in;
         dropped_ff  <= dropped_in;
      end
   end

   genvar i;
   generate
      for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
         logic signed [VALUE_BITS-1:0] l_value, r_value;
         logic                         l_valid, l_ins, r_valid;

         if (i == 0) begin : g_head
            assign l_value = '0;
            assign l_valid = 1'b0;
            assign l_ins   = 1'b0;
         end else begin : g_body
            assign l_value = cell_value[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_ins   = cell_ins[i-1];
         end

         if (i == MAX_ITEMS - 1) begin : g_tail
            assign r_value = '0;
            assign r_valid = 1'b0;
         end else begin : g_inner
            assign r_value = cell_value[i+1];
            assign r_valid = cell_valid[i+1];
         end

         isort_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .new_value   (req_data.value),
            .left_value  (l_value),
            .left_valid  (l_valid),
            .left_ins    (l_ins),
            .right_value (r_value),
            .right_valid (r_valid),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .ins         (cell_ins[i])
         );
      end
   endgenerate

   assign busy                  = draining_ff;
   assign rsp_valid             = draining_ff && cell_valid[0];
   assign rsp_data.sorted_value = cell_value[0];
   assign rsp_data.final_res    = !cell_valid[1];
   assign rsp_data.overflow     = dropped_ff;

endmodule
